>>> sv/stq_pkg.sv
// ----------------------------------------------------------------------------
// stq_pkg
// shared types, constants and combine helpers for the segment tree query core
// ----------------------------------------------------------------------------
package stq_pkg;

	localparam int LEAVES        = 1024;
	localparam int LEAF_BITS     = $clog2(LEAVES);
	localparam int NODES         = 2 * LEAVES;
	localparam int NODE_BITS     = LEAF_BITS + 1;
	localparam int EXT_BITS      = NODE_BITS + 1;
	localparam int VALUE_BITS    = 32;
	localparam int SIZE_BITS     = 11;
	localparam int OP_BITS       = 2;
	localparam int CFG_IDX_BITS  = 2;
	localparam int CFG_DATA_BITS = 11;

	// request opcodes
	localparam logic [OP_BITS-1:0] OP_SET   = 2'd0;
	localparam logic [OP_BITS-1:0] OP_GET   = 2'd1;
	localparam logic [OP_BITS-1:0] OP_QUERY = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_BITS-1:0] CFG_COMBINE_MODE = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_USED_SIZE    = 2'd1;

	typedef logic signed [VALUE_BITS-1:0] value_t;
	typedef logic [NODE_BITS-1:0] node_t;

	typedef struct packed {
		logic [OP_BITS-1:0] op;
		logic [9:0]         position;
		logic signed [31:0] value;
		logic [9:0]         range_left;
		logic [10:0]        range_right;
	} stq_req_t;

	typedef struct packed {
		logic signed [31:0] result_value;
		logic               bad_request;
	} stq_rsp_t;

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic clr_start;
		logic clr_wr;
		logic set_leaf;
		logic set_up;
		logic get_rd;
		logic qry_step;
		logic res_get;
		logic res_acc;
		logic out_load;
	} stq_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic op_set;
		logic op_get;
		logic op_qry;
		logic bad;
		logic clr_done;
		logic up_done;
		logic qry_done;
		logic pipe_idle;
		logic out_free;
	} stq_sts_t;

	localparam value_t VALUE_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
	localparam value_t VALUE_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};

	// mode 0 is min, mode 1 is max
	function automatic value_t stq_identity(input logic mode);
		return mode ? VALUE_MIN : VALUE_MAX;
	endfunction

	function automatic value_t stq_combine(input logic mode, input value_t a, input value_t b);
		logic a_gt;
		a_gt = (a > b);
		if (mode)
			return a_gt ? a : b;
		return a_gt ? b : a;
	endfunction

endpackage

>>> sv/segment_tree_range_query_core.sv
// ----------------------------------------------------------------------------
// segment_tree_range_query_core
// bottom-up min/max segment tree over 1024 signed 32-bit leaves
// ----------------------------------------------------------------------------
// usage
//   req channel (valid/ready) carries one request transaction: point set,
//   point get or half-open range query; rsp channel (valid/ready) returns
//   one transaction per get, query or rejected request; a good set returns
//   nothing and opcode 3 is dropped
//   cfg channel writes combine_mode (index 0) or used_size (index 1); it is
//   always ready, and any write of a known register clears every node to
//   the identity of the new mode
// timing
//   point set: after acceptance, one tree level per cycle through the node
//   memory (leaf write, then ten ancestor writes)
//   point get: leaf read (GET), result capture (GETD), then output load
//   (RESP); range query: one walker step per cycle for up to 11 levels, a
//   step that sees the walk end, a drain of the fold pipeline, then the
//   result register; a bad request goes straight to the output load (RESP)
// reset and stalls
//   reset (and each config write) starts a clearing sweep over every node of
//   the node memory, during which req_ready stays low
//   a result waits in the output register while rsp_ready is low; the next
//   request is still taken, and its own result holds back until the slot frees
// ----------------------------------------------------------------------------
module segment_tree_range_query_core import stq_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	// request channel
	input  logic                     req_valid,
	output logic                     req_ready,
	input  stq_req_t                 req,
	// response channel
	output logic                     rsp_valid,
	input  logic                     rsp_ready,
	output stq_rsp_t                 rsp,
	// configuration channel
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data
);

	// configuration registers
	logic                 combine_mode_q;
	logic [SIZE_BITS-1:0] used_size_q;
	logic                 cfg_wr;

	stq_cmd_t cmd;
	stq_sts_t sts;

	// writes to unknown indexes complete but change nothing
	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready &&
	                   (cfg_index == CFG_COMBINE_MODE || cfg_index == CFG_USED_SIZE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			combine_mode_q <= 1'b1;
			used_size_q    <= SIZE_BITS'(LEAVES);
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == CFG_COMBINE_MODE)
				combine_mode_q <= cfg_data[0];
			else if (cfg_index == CFG_USED_SIZE)
				used_size_q <= cfg_data[SIZE_BITS-1:0];
		end
	end

	// sequencer
	stq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_wr    (cfg_wr),
		.req_valid (req_valid),
		.sts       (sts),
		.req_ready (req_ready),
		.cmd       (cmd)
	);

	// node memory, walkers and output register
	stq_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.req          (req),
		.combine_mode (combine_mode_q),
		.used_size    (used_size_q),
		.rsp_ready    (rsp_ready),
		.sts          (sts),
		.rsp_valid    (rsp_valid),
		.rsp          (rsp)
	);

	// a loaded result never overwrites one still waiting
	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> sts.out_free)
		else $error("result loaded over a pending response");

	// a register write starts the sweep, so no request is taken next cycle
	a_cfg_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr |=> !req_ready)
		else $error("request accepted right after a config write");

	// the node memory has one writer per cycle
	a_one_writer: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.clr_wr, cmd.set_leaf, cmd.set_up}))
		else $error("conflicting node memory writes");

	// a new request only starts with the fold pipeline empty
	a_pipe_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |-> sts.pipe_idle)
		else $error("request accepted with fold pipeline busy");

endmodule

>>> sv/stq_dp.sv
// ----------------------------------------------------------------------------
// stq_dp
// node memory, index walkers, fold pipeline and result register
// ----------------------------------------------------------------------------
module stq_dp import stq_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  stq_cmd_t             cmd,
	input  stq_req_t             req,
	input  logic                 combine_mode,
	input  logic [SIZE_BITS-1:0] used_size,
	input  logic                 rsp_ready,
	output stq_sts_t             sts,
	output logic                 rsp_valid,
	output stq_rsp_t             rsp
);

	value_t mem [NODES];

	value_t               rdata_l_s1;
	value_t               rdata_r_s1;
	logic                 fl_s1;
	logic                 fr_s1;
	logic                 v_s1;
	value_t               pair_s2;
	logic                 v_s2;
	node_t                k_q;
	value_t               val_q;
	logic [EXT_BITS-1:0]  a_q;
	logic [EXT_BITS-1:0]  b_q;
	value_t               acc_q;
	stq_rsp_t             res_q;
	stq_rsp_t             rsp_q;
	logic                 rsp_valid_q;
	node_t                clr_q;

	value_t               identity;
	logic [SIZE_BITS-1:0] n_eff;
	logic                 pos_bad;
	logic                 rng_bad;
	node_t                parent;
	value_t               up_comb;
	logic [EXT_BITS-1:0]  b_m1;
	logic                 a_lt_b;
	node_t                raddr_l;
	node_t                raddr_r;
	node_t                waddr;
	value_t               wdata;
	logic                 we;
	value_t               sel_l;
	value_t               sel_r;

	assign identity = stq_identity(combine_mode);
	assign n_eff    = (used_size > SIZE_BITS'(LEAVES)) ? SIZE_BITS'(LEAVES) : used_size;
	assign pos_bad  = ({1'b0, req.position} >= n_eff);
	assign rng_bad  = ({1'b0, req.range_left} > req.range_right) || (req.range_right > n_eff);

	assign parent  = k_q >> 1;
	assign up_comb = stq_combine(combine_mode, val_q, rdata_l_s1);
	assign b_m1    = b_q - EXT_BITS'(1);
	assign a_lt_b  = (a_q < b_q);

	// read ports: left walker / set sibling / leaf, right walker
	always_comb begin
		if (cmd.qry_step)
			raddr_l = a_q[NODE_BITS-1:0];
		else if (cmd.set_leaf)
			raddr_l = k_q ^ NODE_BITS'(1);
		else if (cmd.set_up)
			raddr_l = parent ^ NODE_BITS'(1);
		else if (cmd.get_rd)
			raddr_l = k_q;
		else
			raddr_l = '0;
	end
	assign raddr_r = b_m1[NODE_BITS-1:0];

	always_comb begin
		we    = cmd.clr_wr | cmd.set_leaf | cmd.set_up;
		waddr = clr_q;
		wdata = identity;
		if (cmd.set_leaf) begin
			waddr = k_q;
			wdata = val_q;
		end else if (cmd.set_up) begin
			waddr = parent;
			wdata = up_comb;
		end
	end

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata_l_s1 <= mem[raddr_l];
		rdata_r_s1 <= mem[raddr_r];
	end

	assign sel_l = fl_s1 ? rdata_l_s1 : identity;
	assign sel_r = fr_s1 ? rdata_r_s1 : identity;

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			k_q   <= NODE_BITS'(LEAVES) | NODE_BITS'(req.position);
			val_q <= req.value;
			a_q   <= EXT_BITS'(LEAVES) + EXT_BITS'(req.range_left);
			b_q   <= EXT_BITS'(LEAVES) + EXT_BITS'(req.range_right);
		end else if (cmd.set_up) begin
			k_q   <= parent;
			val_q <= up_comb;
		end else if (cmd.qry_step && a_lt_b) begin
			a_q <= (a_q + EXT_BITS'(a_q[0])) >> 1;
			b_q <= (b_q - EXT_BITS'(b_q[0])) >> 1;
		end
		fl_s1   <= a_q[0];
		fr_s1   <= b_q[0];
		pair_s2 <= stq_combine(combine_mode, sel_l, sel_r);
		if (cmd.capture)
			acc_q <= identity;
		else if (v_s2)
			acc_q <= stq_combine(combine_mode, acc_q, pair_s2);
		if (cmd.res_get)
			res_q <= '{result_value: rdata_l_s1, bad_request: 1'b0};
		else if (cmd.res_acc)
			res_q <= '{result_value: acc_q, bad_request: 1'b0};
		else if (cmd.capture)
			res_q <= '{result_value: '0, bad_request: 1'b1};
		if (cmd.out_load)
			rsp_q <= res_q;
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			rsp_valid_q <= 1'b0;
			clr_q       <= '0;
		end else begin
			v_s1 <= cmd.qry_step && a_lt_b;
			v_s2 <= v_s1;
			if (cmd.out_load)
				rsp_valid_q <= 1'b1;
			else if (rsp_ready)
				rsp_valid_q <= 1'b0;
			if (cmd.clr_start)
				clr_q <= '0;
			else if (cmd.clr_wr)
				clr_q <= clr_q + NODE_BITS'(1);
		end
	end

	always_comb begin
		sts.op_set    = (req.op == OP_SET);
		sts.op_get    = (req.op == OP_GET);
		sts.op_qry    = (req.op == OP_QUERY);
		sts.bad       = (sts.op_set || sts.op_get) ? pos_bad : rng_bad;
		sts.clr_done  = &clr_q;
		sts.up_done   = (parent == NODE_BITS'(1));
		sts.qry_done  = !a_lt_b;
		sts.pipe_idle = !v_s1 && !v_s2;
		sts.out_free  = !rsp_valid_q || rsp_ready;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

>>> sv/stq_ctrl.sv
// ----------------------------------------------------------------------------
// stq_ctrl
// sequencer for clearing sweep, point set/get and range query
// ----------------------------------------------------------------------------
module stq_ctrl import stq_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     cfg_valid,
	input  logic     cfg_wr,
	input  logic     req_valid,
	input  stq_sts_t sts,
	output logic     req_ready,
	output stq_cmd_t cmd
);

	typedef enum logic [8:0] {
		ST_CLEAR = 9'b000000001,
		ST_IDLE  = 9'b000000010,
		ST_LEAF  = 9'b000000100,
		ST_UP    = 9'b000001000,
		ST_GET   = 9'b000010000,
		ST_GETD  = 9'b000100000,
		ST_QRY   = 9'b001000000,
		ST_QDRN  = 9'b010000000,
		ST_RESP  = 9'b100000000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		cmd       = '0;
		state_d   = state_q;
		req_ready = (state_q == ST_IDLE) && !cfg_valid;
		if (cfg_wr) begin
			cmd.clr_start = 1'b1;
			state_d       = ST_CLEAR;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					cmd.clr_wr = 1'b1;
					if (sts.clr_done)
						state_d = ST_IDLE;
				end
				ST_IDLE: begin
					if (req_valid && req_ready) begin
						cmd.capture = 1'b1;
						if (sts.op_set || sts.op_get || sts.op_qry) begin
							if (sts.bad)
								state_d = ST_RESP;
							else if (sts.op_set)
								state_d = ST_LEAF;
							else if (sts.op_get)
								state_d = ST_GET;
							else
								state_d = ST_QRY;
						end
					end
				end
				ST_LEAF: begin
					cmd.set_leaf = 1'b1;
					state_d      = ST_UP;
				end
				ST_UP: begin
					cmd.set_up = 1'b1;
					if (sts.up_done)
						state_d = ST_IDLE;
				end
				ST_GET: begin
					cmd.get_rd = 1'b1;
					state_d    = ST_GETD;
				end
				ST_GETD: begin
					cmd.res_get = 1'b1;
					state_d     = ST_RESP;
				end
				ST_QRY: begin
					cmd.qry_step = 1'b1;
					if (sts.qry_done)
						state_d = ST_QDRN;
				end
				ST_QDRN: begin
					if (sts.pipe_idle) begin
						cmd.res_acc = 1'b1;
						state_d     = ST_RESP;
					end
				end
				ST_RESP: begin
					if (sts.out_free) begin
						cmd.out_load = 1'b1;
						state_d      = ST_IDLE;
					end
				end
				default: begin
					state_d = ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_CLEAR;
		else
			state_q <= state_d;
	end

endmodule
